// ===== sv/htu_pkg.sv =====
// Shared types and constants for the homogeneous transform unit.
package htu_pkg;

    localparam int NUM_COEF    = 25;
    localparam int INV_BASE    = 16;
    localparam int COORD_WIDTH = 32;

    typedef enum logic [2:0] {
        CMD_LOAD   = 3'd0,
        CMD_POINT  = 3'd1,
        CMD_VECTOR = 3'd2,
        CMD_NORMAL = 3'd3,
        CMD_QUERY  = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [2:0]                   cmd;
        logic [4:0]                   coef_index;
        logic signed [COORD_WIDTH-1:0] coef_value;
        logic signed [COORD_WIDTH-1:0] in_x;
        logic signed [COORD_WIDTH-1:0] in_y;
        logic signed [COORD_WIDTH-1:0] in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic                          w_zero;
        logic                          swaps_handedness;
    } t_out_item;

    // Per-transaction control travelling down the pipeline.
    typedef struct packed {
        logic valid;
        logic point;
        logic query;
    } t_ctl;

endpackage

// ===== sv/homogeneous_transform_unit.sv =====
// Homogeneous transform unit: coefficient store, four row lanes, divide and merge.
// Each transaction passes the lane registers, then the divider and its matching delay
// line, then the merge register.
// Throughput: one transaction per cycle; busy is never raised.
// Reset: coefficients return to identity, the pipeline empties; results cannot stall.
module homogeneous_transform_unit #(
    parameter int FRAC_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  htu_pkg::t_in_item    i_item,
    output logic                 o_strobe,
    output htu_pkg::t_out_item   o_item
);
    localparam int W  = htu_pkg::COORD_WIDTH;
    localparam int DL = W + FRAC_BITS + 2;  // divider latency
    localparam logic signed [W-1:0] One = W'(64'sd1 <<< FRAC_BITS);

    logic signed [W-1:0] r_coef [htu_pkg::NUM_COEF];
    logic acc_in;
    assign busy   = 1'b0;
    assign acc_in = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < htu_pkg::NUM_COEF; i++) begin
                r_coef[i] <= (i == 0 || i == 5 || i == 10 || i == 15 || i == 16
                              || i == 20 || i == 24) ? One : '0;
            end
        end else if (acc_in && i_item.cmd == htu_pkg::CMD_LOAD
                     && i_item.coef_index < 5'(htu_pkg::NUM_COEF)) begin
            r_coef[i_item.coef_index] <= W'(i_item.coef_value);
        end
    end

    // Lane operand selection.
    logic signed [W-1:0] c [4][3];
    logic signed [W-1:0] bias [4];
    logic signed [W-1:0] x, y, z;
    logic is_pt, is_nrm, is_q;
    assign x = W'(i_item.in_x);
    assign y = W'(i_item.in_y);
    assign z = W'(i_item.in_z);
    assign is_pt  = i_item.cmd == htu_pkg::CMD_POINT;
    assign is_nrm = i_item.cmd == htu_pkg::CMD_NORMAL;
    assign is_q   = i_item.cmd == htu_pkg::CMD_QUERY;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 3; k++) begin
                c[r][k] = is_nrm && r < 3 ? r_coef[htu_pkg::INV_BASE + k*3 + r]
                                          : r_coef[r*4 + k];
            end
            bias[r] = is_pt ? r_coef[r*4 + 3] : '0;
        end
    end

    logic signed [W-1:0] sum [4];
    for (genvar r = 0; r < 4; r++) begin : g_lane
        htu_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .i_clk, .i_c0(c[r][0]), .i_c1(c[r][1]), .i_c2(c[r][2]),
            .i_bias(bias[r]), .i_x(x), .i_y(y), .i_z(z), .o_sum(sum[r])
        );
    end

    // Handedness: minors, then terms, then sign of sum (pipelined to lane timing+).
    logic signed [W-1:0] pa [6];
    logic signed [W-1:0] mnr [3];
    logic signed [W-1:0] tm [3];
    logic signed [W-1:0] r_c0, r_c1, r_c2, r_c0b, r_c1b, r_c2b, n_m [3];
    localparam logic signed [W+1:0] MaxV = (W+2)'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W+1:0] MinV = -MaxV - (W+2)'(1);
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a0 (.i_clk, .i_a(r_coef[5]), .i_b(r_coef[10]), .o_p(pa[0]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a1 (.i_clk, .i_a(r_coef[6]), .i_b(r_coef[9]),  .o_p(pa[1]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a2 (.i_clk, .i_a(r_coef[4]), .i_b(r_coef[10]), .o_p(pa[2]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a3 (.i_clk, .i_a(r_coef[6]), .i_b(r_coef[8]),  .o_p(pa[3]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a4 (.i_clk, .i_a(r_coef[4]), .i_b(r_coef[9]),  .o_p(pa[4]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_a5 (.i_clk, .i_a(r_coef[5]), .i_b(r_coef[8]),  .o_p(pa[5]));
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [W+1:0] d;
            d = (W+2)'(pa[2*k]) - (W+2)'(pa[2*k+1]);
            if (d > MaxV)      n_m[k] = MaxV[W-1:0];
            else if (d < MinV) n_m[k] = MinV[W-1:0];
            else               n_m[k] = d[W-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        r_c0 <= r_coef[0]; r_c1 <= r_coef[1]; r_c2 <= r_coef[2];
        r_c0b <= r_c0; r_c1b <= r_c1; r_c2b <= r_c2;
        mnr[0] <= n_m[0]; mnr[1] <= n_m[1]; mnr[2] <= n_m[2];
    end
    htu_mul #(.W(W), .F(FRAC_BITS)) u_t0 (.i_clk, .i_a(r_c0b), .i_b(mnr[0]), .o_p(tm[0]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_t1 (.i_clk, .i_a(r_c1b), .i_b(mnr[1]), .o_p(tm[1]));
    htu_mul #(.W(W), .F(FRAC_BITS)) u_t2 (.i_clk, .i_a(r_c2b), .i_b(mnr[2]), .o_p(tm[2]));
    logic signed [W+1:0] det;
    logic n_neg;
    assign det   = (W+2)'(tm[0]) - (W+2)'(tm[1]) + (W+2)'(tm[2]);
    assign n_neg = det[W+1];

    // Control pipeline to the lane outputs (2 stages).
    htu_pkg::t_ctl r_c1s, r_c2s;
    logic valid_in;
    assign valid_in = acc_in && (is_pt || is_q || is_nrm
                                 || i_item.cmd == htu_pkg::CMD_VECTOR);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1s <= '0;
            r_c2s <= '0;
        end else begin
            r_c1s <= '{valid: valid_in, point: is_pt, query: is_q};
            r_c2s <= r_c1s;
        end
    end

    // Divider lanes; the query sign is registered through the products, the minors and the
    // terms, so it is sampled one stage into the delay line.
    logic signed [W-1:0] q [3];
    for (genvar r = 0; r < 3; r++) begin : g_div
        htu_div #(.W(W), .F(FRAC_BITS)) u_div (
            .i_clk, .i_num(sum[r]), .i_den(sum[3]), .o_q(q[r])
        );
    end

    typedef struct packed {
        logic                valid;
        logic                query;
        logic                wz;
        logic                bypass;
        logic                hand;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
    } t_dly;
    t_dly r_d [DL];
    t_dly n_d0;
    always_comb begin
        n_d0.valid  = r_c2s.valid;
        n_d0.query  = r_c2s.query;
        n_d0.wz     = r_c2s.point && sum[3] == '0;
        n_d0.bypass = !r_c2s.point || sum[3] == One;
        n_d0.hand   = 1'b0;
        n_d0.x      = sum[0];
        n_d0.y      = sum[1];
        n_d0.z      = sum[2];
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DL; s++) r_d[s].valid <= 1'b0;
        end else begin
            for (int s = 0; s < DL; s++) r_d[s].valid <= s == 0 ? n_d0.valid
                                                                : r_d[s-1].valid;
        end
        r_d[0].query <= n_d0.query; r_d[0].wz <= n_d0.wz;
        r_d[0].bypass <= n_d0.bypass; r_d[0].hand <= 1'b0;
        r_d[0].x <= n_d0.x; r_d[0].y <= n_d0.y; r_d[0].z <= n_d0.z;
        for (int s = 1; s < DL; s++) begin
            r_d[s].query <= r_d[s-1].query; r_d[s].wz <= r_d[s-1].wz;
            r_d[s].bypass <= r_d[s-1].bypass;
            r_d[s].hand <= s == 1 ? n_neg : r_d[s-1].hand;
            r_d[s].x <= r_d[s-1].x; r_d[s].y <= r_d[s-1].y; r_d[s].z <= r_d[s-1].z;
        end
    end

    // Merge stage.
    t_dly t;
    assign t = r_d[DL-1];
    htu_pkg::t_out_item n_out, r_out;
    logic r_strobe;
    always_comb begin
        n_out = '0;
        if (t.query) begin
            n_out.swaps_handedness = t.hand;
        end else if (t.wz) begin
            n_out.w_zero = 1'b1;
        end else if (t.bypass) begin
            n_out.out_x = W'(t.x); n_out.out_y = W'(t.y); n_out.out_z = W'(t.z);
        end else begin
            n_out.out_x = W'(q[0]); n_out.out_y = W'(q[1]); n_out.out_z = W'(q[2]);
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= t.valid;
        r_out <= n_out;
    end
    assign o_strobe = r_strobe;
    assign o_item   = r_out;

    a_wz_only_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_item.w_zero |-> o_item.out_x == '0 && !o_item.swaps_handedness)
        else $error("w_zero with nonzero data");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_item.w_zero && o_item.swaps_handedness))
        else $error("both flags set");
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && i_item.cmd == htu_pkg::CMD_LOAD |=> !r_c1s.valid)
        else $error("load produced a result");
endmodule

// ===== sv/htu_mul.sv =====
// Saturating fixed-point multiplier, one registered stage.
module htu_mul #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic signed [W-1:0] o_p
);
    localparam logic signed [2*W-1:0] MaxV = (2*W)'((64'sd1 <<< (W-1)) - 64'sd1);
    localparam logic signed [2*W-1:0] MinV = -(2*W)'(64'sd1 <<< (W-1));

    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] shf;
    logic signed [W-1:0]   n_p;
    logic signed [W-1:0]   r_p;

    always_comb begin
        prod = (2*W)'(i_a) * (2*W)'(i_b);
        shf  = prod >>> F;  // floor
        if (shf > MaxV)      n_p = MaxV[W-1:0];
        else if (shf < MinV) n_p = MinV[W-1:0];
        else                 n_p = shf[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    assign o_p = r_p;
endmodule

// ===== sv/htu_div.sv =====
// Pipelined fixed-point divider: (num << F) / den, truncated, saturated.
module htu_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic signed [W-1:0] o_q
);
    localparam int QW = W + F + 1;
    localparam int N  = W + F;   // quotient bits produced, one per stage

    logic [QW-1:0]  r_rem [N+1];
    logic [N-1:0]   r_dvd [N+1];
    logic [W-1:0]   r_d   [N+1];
    logic [N-1:0]   r_q   [N+1];
    logic           r_neg [N+1];

    logic [W-1:0] mn, md;
    assign mn = i_num[W-1] ? W'(-i_num) : W'(i_num);
    assign md = i_den[W-1] ? W'(-i_den) : W'(i_den);

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_dvd[0] <= {mn, F'(0)};
        r_d[0]   <= md;
        r_q[0]   <= '0;
        r_neg[0] <= i_num[W-1] ^ i_den[W-1];
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [QW-1:0] t;
        assign t = {r_rem[s][QW-2:0], r_dvd[s][N-1]};
        always_ff @(posedge i_clk) begin
            r_dvd[s+1] <= {r_dvd[s][N-2:0], 1'b0};
            r_d[s+1]   <= r_d[s];
            r_neg[s+1] <= r_neg[s];
            if (t >= QW'(r_d[s])) begin
                r_rem[s+1] <= t - QW'(r_d[s]);
                r_q[s+1]   <= {r_q[s][N-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= t;
                r_q[s+1]   <= {r_q[s][N-2:0], 1'b0};
            end
        end
    end

    logic [N-1:0]   q;
    logic signed [W-1:0] n_q, r_out;
    assign q = r_q[N];
    always_comb begin
        if (r_neg[N]) begin
            if (q > N'(1) << (W-1)) n_q = {1'b1, {(W-1){1'b0}}};
            else                    n_q = W'(-q);
        end else begin
            if (q > (N'(1) << (W-1)) - N'(1)) n_q = {1'b0, {(W-1){1'b1}}};
            else                              n_q = q[W-1:0];
        end
    end
    always_ff @(posedge i_clk) r_out <= n_q;
    assign o_q = r_out;
endmodule

// ===== sv/htu_lane.sv =====
// One row lane: three saturating products, then a saturated sum with bias.
module htu_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_c0,
    input  logic signed [W-1:0] i_c1,
    input  logic signed [W-1:0] i_c2,
    input  logic signed [W-1:0] i_bias,
    input  logic signed [W-1:0] i_x,
    input  logic signed [W-1:0] i_y,
    input  logic signed [W-1:0] i_z,
    output logic signed [W-1:0] o_sum
);
    localparam logic signed [W+2:0] MaxV = (W+3)'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [W+2:0] MinV = -MaxV - (W+3)'(1);

    logic signed [W-1:0] p0, p1, p2, r_bias, n_sum, r_sum;
    logic signed [W+2:0] acc;

    htu_mul #(.W(W), .F(F)) u_m0 (.i_clk, .i_a(i_c0), .i_b(i_x), .o_p(p0));
    htu_mul #(.W(W), .F(F)) u_m1 (.i_clk, .i_a(i_c1), .i_b(i_y), .o_p(p1));
    htu_mul #(.W(W), .F(F)) u_m2 (.i_clk, .i_a(i_c2), .i_b(i_z), .o_p(p2));

    always_comb begin
        acc = (W+3)'(p0) + (W+3)'(p1) + (W+3)'(p2) + (W+3)'(r_bias);
        if (acc > MaxV)      n_sum = MaxV[W-1:0];
        else if (acc < MinV) n_sum = MinV[W-1:0];
        else                 n_sum = acc[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_bias <= i_bias;
        r_sum  <= n_sum;
    end
    assign o_sum = r_sum;
endmodule

// ===== dv/tb_homogeneous_transform_unit.sv =====
// Self-checking testbench for the homogeneous transform unit: directed table, then random.
module tb_homogeneous_transform_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 60;
    localparam int WD_LIMIT = 4000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;
    localparam logic [2:0] CMD_BAD = 3'd5;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    htu_pkg::t_in_item  i_item = '0;
    logic      o_strobe;
    htu_pkg::t_out_item o_item;

    homogeneous_transform_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_strobe(o_strobe), .o_item(o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    longint    coef_copy[htu_pkg::NUM_COEF];
    htu_pkg::t_out_item expected_q[$];
    int        errors = 0;
    int        idle_cycles = 0;

    function automatic longint sat32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // Exact 128-bit product, floor shift, saturate.
    function automatic longint qmul(longint a, longint b);
        logic signed [127:0] p;
        p = (128'(signed'(a)) * 128'(signed'(b))) >>> 16;
        if (p > VMAX) return VMAX;
        if (p < VMIN) return VMIN;
        return longint'(p);
    endfunction

    function automatic longint qdiv(longint num, longint den);
        logic signed [127:0] q;
        q = (128'(signed'(num)) <<< 16) / 128'(signed'(den));
        if (q > VMAX) return VMAX;
        if (q < VMIN) return VMIN;
        return longint'(q);
    endfunction

    function automatic longint row_sum(int i0, int s, longint x, longint y, longint z,
                                       longint bias);
        return sat32(qmul(coef_copy[i0], x) + qmul(coef_copy[i0 + s], y)
                     + qmul(coef_copy[i0 + 2 * s], z) + bias);
    endfunction

    function automatic longint minor(int a, int b, int c, int d);
        return sat32(qmul(coef_copy[a], coef_copy[b]) - qmul(coef_copy[c], coef_copy[d]));
    endfunction

    task automatic reset_coefs();
        foreach (coef_copy[i]) coef_copy[i] = 0;
        foreach (coef_copy[i])
            if (i inside {0, 5, 10, 15, 16, 20, 24}) coef_copy[i] = ONE;
    endtask

    // Updates the coefficient copy; returns 1 with the result when one is produced.
    function automatic bit transform_predict(htu_pkg::t_in_item it,
                                             output htu_pkg::t_out_item r);
        longint x, y, z, rx, ry, rz, w;
        r = '0;
        x = longint'(it.in_x);
        y = longint'(it.in_y);
        z = longint'(it.in_z);
        rx = 0; ry = 0; rz = 0;
        case (it.cmd)
            htu_pkg::CMD_LOAD: begin
                if (it.coef_index < htu_pkg::NUM_COEF)
                    coef_copy[it.coef_index] = longint'(it.coef_value);
                return 0;
            end
            htu_pkg::CMD_POINT: begin
                rx = row_sum(0, 1, x, y, z, coef_copy[3]);
                ry = row_sum(4, 1, x, y, z, coef_copy[7]);
                rz = row_sum(8, 1, x, y, z, coef_copy[11]);
                w  = row_sum(12, 1, x, y, z, coef_copy[15]);
                if (w == 0) begin
                    rx = 0; ry = 0; rz = 0;
                    r.w_zero = 1'b1;
                end else if (w != ONE) begin
                    rx = qdiv(rx, w);
                    ry = qdiv(ry, w);
                    rz = qdiv(rz, w);
                end
            end
            htu_pkg::CMD_VECTOR: begin
                rx = row_sum(0, 1, x, y, z, 0);
                ry = row_sum(4, 1, x, y, z, 0);
                rz = row_sum(8, 1, x, y, z, 0);
            end
            htu_pkg::CMD_NORMAL: begin
                rx = row_sum(htu_pkg::INV_BASE + 0, 3, x, y, z, 0);
                ry = row_sum(htu_pkg::INV_BASE + 1, 3, x, y, z, 0);
                rz = row_sum(htu_pkg::INV_BASE + 2, 3, x, y, z, 0);
            end
            htu_pkg::CMD_QUERY: begin
                r.swaps_handedness = (qmul(coef_copy[0], minor(5, 10, 6, 9))
                                      - qmul(coef_copy[1], minor(4, 10, 6, 8))
                                      + qmul(coef_copy[2], minor(4, 9, 5, 8))) < 0;
            end
            default: return 0;
        endcase
        r.out_x = rx[31:0];
        r.out_y = ry[31:0];
        r.out_z = rz[31:0];
        return 1;
    endfunction

    // Result checker; results cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transaction %p", o_item);
                errors++;
            end else begin
                htu_pkg::t_out_item e;
                e = expected_q.pop_front();
                if (o_item.out_x !== e.out_x) begin
                    $error("out_x exp %0d got %0d", e.out_x, o_item.out_x); errors++;
                end
                if (o_item.out_y !== e.out_y) begin
                    $error("out_y exp %0d got %0d", e.out_y, o_item.out_y); errors++;
                end
                if (o_item.out_z !== e.out_z) begin
                    $error("out_z exp %0d got %0d", e.out_z, o_item.out_z); errors++;
                end
                if (o_item.w_zero !== e.w_zero) begin
                    $error("w_zero exp %0b got %0b", e.w_zero, o_item.w_zero); errors++;
                end
                if (o_item.swaps_handedness !== e.swaps_handedness) begin
                    $error("swaps_handedness exp %0b got %0b", e.swaps_handedness,
                           o_item.swaps_handedness);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with neither an accepted transaction nor a result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    typedef struct {
        htu_pkg::t_in_item  it;
        bit                 has_exp;   // result typed in by hand
        htu_pkg::t_out_item exp;
    } t_row;

    t_row directed[$];

    function automatic htu_pkg::t_in_item mk(logic [2:0] c, logic [4:0] idx, int v,
                                             int x, int y, int z);
        htu_pkg::t_in_item t;
        t.cmd = c; t.coef_index = idx; t.coef_value = v;
        t.in_x = x; t.in_y = y; t.in_z = z;
        return t;
    endfunction

    function automatic htu_pkg::t_out_item mo(int x, int y, int z, bit wz, bit h);
        htu_pkg::t_out_item o;
        o.out_x = x; o.out_y = y; o.out_z = z; o.w_zero = wz; o.swaps_handedness = h;
        return o;
    endfunction

    task automatic add_row(htu_pkg::t_in_item it, bit he = 0,
                           htu_pkg::t_out_item e = '0);
        t_row r;
        r.it = it; r.has_exp = he; r.exp = e;
        directed.push_back(r);
    endtask

    task automatic build_table();
        // identity after reset
        add_row(mk(htu_pkg::CMD_POINT, 0, 0, 32'h7fffffff, 32'h80000000, 0), 1,
                mo(32'h7fffffff, 32'h80000000, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_VECTOR, 0, 0, -1, 1, 32'h12345678), 1,
                mo(-1, 1, 32'h12345678, 0, 0));
        add_row(mk(htu_pkg::CMD_NORMAL, 0, 0, 5, -5, 32'h80000000), 1,
                mo(5, -5, 32'h80000000, 0, 0));
        add_row(mk(htu_pkg::CMD_QUERY, 0, 0, 0, 0, 0), 1, mo(0, 0, 0, 0, 0));
        add_row(mk(CMD_BAD, 0, 0, 1, 2, 3));
        add_row(mk(3'd7, 0, 0, 1, 2, 3));
        add_row(mk(htu_pkg::CMD_LOAD, 5'd31, 32'h7fffffff, 0, 0, 0));   // out of range, ignored
        add_row(mk(htu_pkg::CMD_LOAD, 5'd25, 32'h7fffffff, 0, 0, 0));
        // w = 0 with zero bottom row
        add_row(mk(htu_pkg::CMD_LOAD, 15, 0, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_POINT, 0, 0, 100, 200, 300), 1, mo(0, 0, 0, 1, 0));
        // w = 2: divide
        add_row(mk(htu_pkg::CMD_LOAD, 15, 32'h00020000, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_POINT, 0, 0, 32'h00040000, -32'sd3, 32'h7fffffff));
        add_row(mk(htu_pkg::CMD_LOAD, 14, 32'h80000000, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_POINT, 0, 0, 32'h7fffffff, 32'h80000000, 32'h00010000));
        // saturating products, mirror for handedness
        add_row(mk(htu_pkg::CMD_LOAD, 0, 32'h80000000, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_LOAD, 3, 32'h7fffffff, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_VECTOR, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000));
        add_row(mk(htu_pkg::CMD_QUERY, 0, 0, 0, 0, 0), 1, mo(0, 0, 0, 0, 1));
        add_row(mk(htu_pkg::CMD_POINT, 0, 0, 32'hffffffff, 1, 32'h80000000));
        add_row(mk(htu_pkg::CMD_LOAD, 24, 32'h80000000, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_LOAD, 17, 32'h7fffffff, 0, 0, 0));
        add_row(mk(htu_pkg::CMD_NORMAL, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    endtask

    int directed_errs = 0;

    task automatic send(htu_pkg::t_in_item it, bit he, htu_pkg::t_out_item e);
        htu_pkg::t_out_item r;
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (transform_predict(it, r)) begin
            if (he && r !== e) begin
                $error("directed row %p: table %p predictor %p", it, e, r);
                errors++;
            end
            expected_q.push_back(he ? e : r);
        end
    endtask

    task automatic gap();
        int n;
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) n = 0;
        else if (k < 95) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 60);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic int rcoord();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) * 32'h00010000 - 32'h00040000;
            3, 4: return int'($urandom_range(0, 32'h000fffff)) - 32'h00080000;
            default: return $urandom();
        endcase
    endfunction

    function automatic htu_pkg::t_in_item rand_item();
        htu_pkg::t_in_item t;
        int k;
        t.coef_value = rcoord();
        t.in_x = rcoord(); t.in_y = rcoord(); t.in_z = rcoord();
        t.coef_index = $urandom_range(0, 24);
        k = $urandom_range(0, 99);
        if (k < 25) t.cmd = htu_pkg::CMD_LOAD;
        else if (k < 50) t.cmd = htu_pkg::CMD_POINT;
        else if (k < 68) t.cmd = htu_pkg::CMD_VECTOR;
        else if (k < 84) t.cmd = htu_pkg::CMD_NORMAL;
        else if (k < 94) t.cmd = htu_pkg::CMD_QUERY;
        else if (k < 97) t.cmd = 3'($urandom_range(5, 7));
        else begin
            t.cmd = htu_pkg::CMD_LOAD;
            t.coef_index = 5'($urandom_range(25, 31));
        end
        // small bottom row now and then so w = 0 and w = 1 cases recur
        if (t.cmd == htu_pkg::CMD_LOAD && t.coef_index inside {12, 13, 14}
            && $urandom_range(0, 1))
            t.coef_value = 0;
        if (t.cmd == htu_pkg::CMD_LOAD && t.coef_index == 15 && $urandom_range(0, 2) == 0)
            t.coef_value = $urandom_range(0, 1) ? 32'h00010000 : 0;
        return t;
    endfunction

    initial begin
        reset_coefs();
        build_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) begin
            send(directed[i].it, directed[i].has_exp, directed[i].exp);
            gap();
        end
        for (int n = 0; n < 850; n++) begin
            send(rand_item(), 0, '0);
            if (n < 200 || n > 400) gap();   // burst stretch in between
            if (n == 500) begin
                start <= 1'b0;
                while (expected_q.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (errors == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
